// File: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with reset masking
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// value held while a condition stands
`define ASSERT_HOLD(lbl, cond, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

// File: sv/tpe_pkg.sv
// types, codes and reset values for the touch pointer event tracker
`default_nettype none
package tpe_pkg;

	localparam int RAW_W     = 16;
	localparam int OFF_W     = 10;
	localparam int SIZE_W    = 11;
	localparam int POS_W     = 10;
	localparam int TIME_W    = 32;
	localparam int TMO_W     = 16;
	localparam int KIND_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [KIND_W-1:0] EV_DOWN = 2'd0;
	localparam logic [KIND_W-1:0] EV_MOVE = 2'd1;
	localparam logic [KIND_W-1:0] EV_UP   = 2'd2;

	localparam logic CMD_POLL   = 1'b0;
	localparam logic CMD_REPORT = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd4;

	localparam logic [OFF_W-1:0]  RST_OFFSET_X = 10'd49;
	localparam logic [OFF_W-1:0]  RST_OFFSET_Y = 10'd9;
	localparam logic [SIZE_W-1:0] RST_WIDTH    = 11'd184;
	localparam logic [SIZE_W-1:0] RST_HEIGHT   = 11'd224;
	localparam logic [TMO_W-1:0]  RST_TIMEOUT  = 16'd120;

	localparam logic [SIZE_W-1:0] SIZE_MAX = 11'd1024;

	typedef struct packed {
		logic              cmd;
		logic [TIME_W-1:0] now_ms;
		logic              touched;
		logic [RAW_W-1:0]  raw_x;
		logic [RAW_W-1:0]  raw_y;
	} tpe_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [TIME_W-1:0] t;
	} tpe_event_t;

endpackage
`default_nettype wire

// File: sv/tpe_map.sv
// raw to logical coordinate mapping: offset, halve, clamp
`default_nettype none
module tpe_map (
	input  logic [tpe_pkg::RAW_W-1:0]  raw,
	input  logic [tpe_pkg::OFF_W-1:0]  off,
	input  logic [tpe_pkg::SIZE_W-1:0] size,
	output logic [tpe_pkg::POS_W-1:0]  pos
);
	import tpe_pkg::*;

	logic [SIZE_W-1:0] size_m1;
	logic [POS_W-1:0]  hi;
	logic [RAW_W-1:0]  diff;
	logic [RAW_W-2:0]  half;

	always_comb begin
		size_m1 = size - SIZE_W'(1);
		if (size == '0) begin
			hi = '0;
		end else if (size > SIZE_MAX) begin
			hi = '1;
		end else begin
			hi = size_m1[POS_W-1:0];
		end
		diff = raw - RAW_W'(off);
		half = diff[RAW_W-1:1];
		if (raw <= RAW_W'(off)) begin
			pos = '0;
		end else if (half > (RAW_W-1)'(hi)) begin
			pos = hi;
		end else begin
			pos = half[POS_W-1:0];
		end
	end

endmodule
`default_nettype wire

// File: sv/tpe_track.sv
// pointer state and event decision for one item
`default_nettype none
module tpe_track (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  tpe_pkg::tpe_item_t         item,
	input  logic [tpe_pkg::POS_W-1:0]  map_x,
	input  logic [tpe_pkg::POS_W-1:0]  map_y,
	input  logic [tpe_pkg::TMO_W-1:0]  timeout,
	output logic                       res_valid,
	output tpe_pkg::tpe_event_t        res
);
	import tpe_pkg::*;

	logic              down_q;
	logic [POS_W-1:0]  held_x_q;
	logic [POS_W-1:0]  held_y_q;
	logic [TIME_W-1:0] last_time_q;

	logic              down_n;
	logic [POS_W-1:0]  held_x_n;
	logic [POS_W-1:0]  held_y_n;
	logic [TIME_W-1:0] last_time_n;
	logic [TIME_W-1:0] elapsed;

	always_comb begin
		down_n      = down_q;
		held_x_n    = held_x_q;
		held_y_n    = held_y_q;
		last_time_n = last_time_q;
		res_valid   = 1'b0;
		res.kind    = EV_UP;
		res.x       = held_x_q;
		res.y       = held_y_q;
		res.t       = item.now_ms;
		elapsed     = item.now_ms - last_time_q;
		if (item.cmd == CMD_POLL) begin
			if (down_q && (elapsed >= TIME_W'(timeout))) begin
				down_n    = 1'b0;
				res_valid = 1'b1;
			end
		end else if (item.touched) begin
			last_time_n = item.now_ms;
			res.x       = map_x;
			res.y       = map_y;
			held_x_n    = map_x;
			held_y_n    = map_y;
			if (!down_q) begin
				down_n    = 1'b1;
				res_valid = 1'b1;
				res.kind  = EV_DOWN;
			end else if ((map_x != held_x_q) || (map_y != held_y_q)) begin
				res_valid = 1'b1;
				res.kind  = EV_MOVE;
			end
		end else if (down_q) begin
			down_n    = 1'b0;
			res_valid = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_q      <= 1'b0;
			held_x_q    <= '0;
			held_y_q    <= '0;
			last_time_q <= '0;
		end else if (fire) begin
			down_q      <= down_n;
			held_x_q    <= held_x_n;
			held_y_q    <= held_y_n;
			last_time_q <= last_time_n;
		end
	end

endmodule
`default_nettype wire

// File: sv/touch_pointer_event_tracker_unit.sv
// top level of the touch pointer event tracker
// Turns touch controller reports and time polls into down, move and up pointer
// events. An input beat is registered, its coordinates mapped and the pointer
// state updated as the beat leaves the input stage, when any event also lands
// in the output register. One beat per cycle is sustained while the output
// side takes beats, set by the single input stage and single output register.
// Register writes take effect at once and belong in idle periods.
`default_nettype none
module touch_pointer_event_tracker_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             cmd,
	input  logic [tpe_pkg::TIME_W-1:0]       now_ms,
	input  logic                             touched,
	input  logic [tpe_pkg::RAW_W-1:0]        raw_x,
	input  logic [tpe_pkg::RAW_W-1:0]        raw_y,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tpe_pkg::KIND_W-1:0]       event_kind,
	output logic [tpe_pkg::POS_W-1:0]        pos_x,
	output logic [tpe_pkg::POS_W-1:0]        pos_y,
	output logic [tpe_pkg::TIME_W-1:0]       event_time,
	input  logic                             cfg_wr_en,
	input  logic [tpe_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [tpe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import tpe_pkg::*;

	logic [OFF_W-1:0]  off_x_q;
	logic [OFF_W-1:0]  off_y_q;
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic [TMO_W-1:0]  timeout_q;

	logic       valid_s1;
	tpe_item_t  item_s1;
	logic       valid_s2;
	tpe_event_t event_s2;

	logic       adv;
	logic       fire;
	logic [POS_W-1:0] map_x;
	logic [POS_W-1:0] map_y;
	logic       res_valid;
	tpe_event_t res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q   <= RST_OFFSET_X;
			off_y_q   <= RST_OFFSET_Y;
			width_q   <= RST_WIDTH;
			height_q  <= RST_HEIGHT;
			timeout_q <= RST_TIMEOUT;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_OFFSET_X: off_x_q   <= cfg_wdata[OFF_W-1:0];
				REG_OFFSET_Y: off_y_q   <= cfg_wdata[OFF_W-1:0];
				REG_WIDTH:    width_q   <= cfg_wdata[SIZE_W-1:0];
				REG_HEIGHT:   height_q  <= cfg_wdata[SIZE_W-1:0];
				REG_TIMEOUT:  timeout_q <= cfg_wdata[TMO_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv      = !valid_s2 || out_ready;
	assign fire     = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.cmd     <= cmd;
			item_s1.now_ms  <= now_ms;
			item_s1.touched <= touched;
			item_s1.raw_x   <= raw_x;
			item_s1.raw_y   <= raw_y;
		end
	end

	tpe_map u_map_x (
		.raw  (item_s1.raw_x),
		.off  (off_x_q),
		.size (width_q),
		.pos  (map_x)
	);

	tpe_map u_map_y (
		.raw  (item_s1.raw_y),
		.off  (off_y_q),
		.size (height_q),
		.pos  (map_y)
	);

	tpe_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.map_x     (map_x),
		.map_y     (map_y),
		.timeout   (timeout_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			event_s2 <= res;
		end
	end

	assign out_valid  = valid_s2;
	assign event_kind = event_s2.kind;
	assign pos_x      = event_s2.x;
	assign pos_y      = event_s2.y;
	assign event_time = event_s2.t;

endmodule
`default_nettype wire

// File: sv/tpe_checker.sv
// port level checks for the touch pointer event tracker, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module tpe_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [tpe_pkg::KIND_W-1:0]     event_kind,
	input logic [tpe_pkg::POS_W-1:0]      pos_x,
	input logic [tpe_pkg::POS_W-1:0]      pos_y,
	input logic [tpe_pkg::TIME_W-1:0]     event_time
);
	import tpe_pkg::*;

	// stalled beat keeps its payload
	`ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(pos_x) && $stable(pos_y) && $stable(event_time), "stalled output beat changed")
	`ASSERT_CLK(a_kind_legal, out_valid |-> (event_kind == EV_DOWN || event_kind == EV_MOVE || event_kind == EV_UP), "illegal event kind")
	// empty output register never blocks input
	`ASSERT_CLK(a_ready_when_empty, !out_valid |-> in_ready, "input blocked with output register empty")
	// a beat taken last cycle sits in the input stage behind a stalled output
	`ASSERT_CLK(a_backpressure, $past(arst_n) && $past(in_valid && in_ready) && out_valid && !out_ready |-> !in_ready, "input stage overrun")

endmodule

bind touch_pointer_event_tracker_unit tpe_checker u_tpe_checker (.*);
`default_nettype wire
